// ===== sv/interval_scheduling_select_macros.svh =====
// ----------------------------------------------------------------------------
// Interval scheduling select assertion macros
// Shared assertion shorthands, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SCHEDULING_SELECT_MACROS_SVH
`define INTERVAL_SCHEDULING_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/iss_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval scheduling select package
// Sizes, transfer types, controller states and the control interface.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam int MaxIntervals = 16;
  localparam int OutLimit     = 16;
  localparam int DataW        = 16;
  localparam int IdxW         = $clog2(MaxIntervals);
  localparam int CntW         = $clog2(MaxIntervals + 1);
  localparam int SelIdxW      = 4;
  localparam int SelTotW      = 5;

  typedef struct packed {
    logic signed [DataW-1:0] iv_start;
    logic signed [DataW-1:0] iv_end;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sel_start;
    logic signed [DataW-1:0] sel_end;
    logic [SelIdxW-1:0]      sel_index;
    logic [SelTotW-1:0]      sel_total;
    logic                    final_flag;
    logic                    overflow;
  } res_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWait,
    StCommit,
    StEmit,
    StFlush
  } iss_state_e;

  typedef struct packed {
    logic load;
    logic run_init;
    logic scan_rd;
    logic commit;
    logic emit_rd;
    logic clear;
  } iss_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic keep_full;
    logic emit_end;
  } iss_status_t;

endpackage

`default_nettype wire

// ===== sv/interval_scheduling_select.sv =====
// ----------------------------------------------------------------------------
// Interval scheduling select
// Greedy earliest-finish selection over a loaded set of intervals.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_i and raise start; a transfer happens at each rising
//   edge with start high and busy low. Items are taken one per cycle.
//   The item with is_last set closes the set. Items beyond 16 are dropped
//   and reported through the overflow field.
//   After the closing transfer busy rises. The block then runs one pass
//   over the stored intervals per kept interval, plus a final pass that
//   finds nothing (none once 16 are kept). Each pass reads the N stored
//   intervals one at a time through the single read port of the store.
//   Output: the K kept intervals appear on res_o in order of ascending end,
//   one per cycle on consecutive cycles, each marked by res_strobe_o for one
//   cycle; the transfer completes at the edge ending that cycle. There is no
//   back-pressure. Busy falls once emission has finished.
//   Reset: the set is emptied, the overflow mark cleared and the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_scheduling_select import iss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  in_i,
  output logic      busy,
  output logic      res_strobe_o,
  output res_item_t res_o
);

  iss_cmd_t    cmd;
  iss_status_t status;

  iss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .is_last_i (in_i.is_last),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  iss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_i         (in_i),
    .status_o     (status),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

`include "interval_scheduling_select_macros.svh"

  `ISS_ASSERT_SAME(a_strobe_busy, res_strobe_o, busy, "result strobe while idle")
  `ISS_ASSERT_NEXT(a_last_busy, start && !busy && in_i.is_last, busy,
    "closing transfer did not start selection")
  `ISS_ASSERT_NEXT(a_final_ends, res_strobe_o && res_o.final_flag, !res_strobe_o,
    "result after the final one")
  `ISS_ASSERT_NEXT(a_index_seq, res_strobe_o && !res_o.final_flag,
    res_strobe_o && (res_o.sel_index == SelIdxW'($past(res_o.sel_index) + 1'b1)),
    "result index out of sequence")

endmodule

`default_nettype wire

// ===== sv/iss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Interval scheduling select controller
// Sequences loading, the selection passes over the store and the emission.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_ctrl import iss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_last_i,
  input  iss_status_t status_i,
  output iss_cmd_t    cmd_o,
  output logic        busy_o
);

  iss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (is_last_i) begin
            cmd_o.run_init = 1'b1;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_end) begin
          state_d = StWait;
        end
      end
      // The last read of the pass is compared in this cycle.
      StWait: begin
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        if (status_i.found && !status_i.keep_full) begin
          state_d = StScan;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit_rd = 1'b1;
        if (status_i.emit_end) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        cmd_o.clear = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/iss_dp.sv =====
// ----------------------------------------------------------------------------
// Interval scheduling select datapath
// Interval store, selection search, kept-position list and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_dp import iss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iss_cmd_t    cmd_i,
  input  in_item_t    in_i,
  output iss_status_t status_o,
  output logic        res_strobe_o,
  output res_item_t   res_o
);

  logic signed [DataW-1:0] mem_start [MaxIntervals];
  logic signed [DataW-1:0] mem_end   [MaxIntervals];
  logic [IdxW-1:0]         keep_q    [MaxIntervals];

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    drop_q, drop_d;
  logic [CntW-1:0]         scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0]         nkeep_q, nkeep_d;
  logic [CntW-1:0]         emit_ptr_q, emit_ptr_d;
  logic                    first_q, first_d;
  logic                    found_q, found_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic signed [DataW-1:0] best_end_q, best_end_d;
  logic [IdxW-1:0]         prev_idx_q, prev_idx_d;
  logic signed [DataW-1:0] last_end_q, last_end_d;
  logic                    scan_vld_q, emit_vld_q;

  logic signed [DataW-1:0] rd_start_q, rd_end_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic [SelIdxW-1:0]      emit_idx_q;

  logic [IdxW-1:0]         rd_addr;
  logic                    rd_en;
  logic                    key_after, eligible, better, take;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CntW'(MaxIntervals))) begin
      mem_start[cnt_q[IdxW-1:0]] <= in_i.iv_start;
      mem_end[cnt_q[IdxW-1:0]]   <= in_i.iv_end;
    end
  end

  assign rd_addr = cmd_i.emit_rd ? keep_q[emit_ptr_q[IdxW-1:0]] : scan_ptr_q[IdxW-1:0];
  assign rd_en   = cmd_i.scan_rd | cmd_i.emit_rd;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_end_q   <= mem_end[rd_addr];
      rd_idx_q   <= rd_addr;
    end
    if (cmd_i.emit_rd) begin
      emit_idx_q <= emit_ptr_q[SelIdxW-1:0];
    end
    if (cmd_i.commit && found_q) begin
      keep_q[nkeep_q[IdxW-1:0]] <= best_idx_q;
    end
  end

  // A candidate must come after the previous pick in (end, arrival) order and
  // start no earlier than its end; the first pass takes any interval.
  assign key_after = (rd_end_q > last_end_q) ||
                     ((rd_end_q == last_end_q) && (rd_idx_q > prev_idx_q));
  assign eligible  = first_q || (key_after && (rd_start_q >= last_end_q));
  // Strict compare keeps the earliest arrival among equal ends.
  assign better    = !found_q || (rd_end_q < best_end_q);
  assign take      = scan_vld_q && eligible && better;

  always_comb begin
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    scan_ptr_d = scan_ptr_q;
    nkeep_d    = nkeep_q;
    emit_ptr_d = emit_ptr_q;
    first_d    = first_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_end_d = best_end_q;
    prev_idx_d = prev_idx_q;
    last_end_d = last_end_q;

    if (cmd_i.load) begin
      if (cnt_q < CntW'(MaxIntervals)) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.run_init) begin
      nkeep_d    = '0;
      first_d    = 1'b1;
      scan_ptr_d = '0;
      found_d    = 1'b0;
    end
    if (cmd_i.scan_rd) begin
      scan_ptr_d = scan_ptr_q + CntW'(1);
    end
    if (take) begin
      found_d    = 1'b1;
      best_idx_d = rd_idx_q;
      best_end_d = rd_end_q;
    end
    if (cmd_i.commit) begin
      if (found_q) begin
        nkeep_d    = nkeep_q + CntW'(1);
        last_end_d = best_end_q;
        prev_idx_d = best_idx_q;
        first_d    = 1'b0;
      end
      scan_ptr_d = '0;
      found_d    = 1'b0;
      emit_ptr_d = '0;
    end
    if (cmd_i.emit_rd) begin
      emit_ptr_d = emit_ptr_q + CntW'(1);
    end
    if (cmd_i.clear) begin
      cnt_d  = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      scan_ptr_q <= '0;
      nkeep_q    <= '0;
      emit_ptr_q <= '0;
      first_q    <= 1'b1;
      found_q    <= 1'b0;
      scan_vld_q <= 1'b0;
      emit_vld_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      scan_ptr_q <= scan_ptr_d;
      nkeep_q    <= nkeep_d;
      emit_ptr_q <= emit_ptr_d;
      first_q    <= first_d;
      found_q    <= found_d;
      scan_vld_q <= cmd_i.scan_rd;
      emit_vld_q <= cmd_i.emit_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_end_q <= best_end_d;
    prev_idx_q <= prev_idx_d;
    last_end_q <= last_end_d;
  end

  assign status_o.scan_end  = (scan_ptr_q == cnt_q - CntW'(1));
  assign status_o.found     = found_q;
  assign status_o.keep_full = (nkeep_q == CntW'(OutLimit - 1));
  assign status_o.emit_end  = (emit_ptr_q == nkeep_q - CntW'(1));

  assign res_strobe_o     = emit_vld_q;
  assign res_o.sel_start  = rd_start_q;
  assign res_o.sel_end    = rd_end_q;
  assign res_o.sel_index  = emit_idx_q;
  assign res_o.sel_total  = SelTotW'(nkeep_q);
  assign res_o.final_flag = (CntW'(emit_idx_q) == nkeep_q - CntW'(1));
  assign res_o.overflow   = drop_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Interval scheduling select testbench
// Loads interval sets through the start/busy command port and predicts the
// earliest-finish selection with a stable sort per set. Every strobed result
// is compared field by field against the oldest prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import iss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int MaxPrinted = 50;

  // Predicts the kept intervals of each set and holds them until they are seen.
  class sched_scoreboard;
    logic signed [DataW-1:0] start_mem [MaxIntervals];
    logic signed [DataW-1:0] end_mem [MaxIntervals];
    int unsigned n_loaded;
    bit          dropped;
    res_item_t   kept_q [$];
    int unsigned n_errors;
    int unsigned n_items;
    int unsigned n_sets;
    int unsigned n_overflow_sets;
    int unsigned n_checked;

    function new();
      n_loaded        = 0;
      dropped         = 1'b0;
      n_errors        = 0;
      n_items         = 0;
      n_sets          = 0;
      n_overflow_sets = 0;
      n_checked       = 0;
    endfunction

    task report(input string msg);
      if (n_errors < MaxPrinted) begin
        $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      n_errors++;
    endtask

    // Called for every accepted input transfer.
    function void note_item(input in_item_t it);
      int                      by_end [MaxIntervals];
      int                      kept_pos [MaxIntervals];
      int                      j;
      int                      n_kept;
      int                      n_out;
      logic signed [DataW-1:0] last_end;
      res_item_t               r;
      n_items++;
      if (n_loaded < MaxIntervals) begin
        start_mem[n_loaded] = it.iv_start;
        end_mem[n_loaded]   = it.iv_end;
        n_loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!it.is_last) return;

      // Insertion sort on end; strict compare keeps equal ends in arrival order.
      for (int i = 0; i < n_loaded; i++) begin
        j = i;
        while (j > 0 && end_mem[by_end[j-1]] > end_mem[i]) begin
          by_end[j] = by_end[j-1];
          j--;
        end
        by_end[j] = i;
      end

      n_kept   = 0;
      last_end = '0;
      for (int i = 0; i < n_loaded; i++) begin
        if (n_kept == 0 || start_mem[by_end[i]] >= last_end) begin
          kept_pos[n_kept] = by_end[i];
          n_kept++;
          last_end = end_mem[by_end[i]];
        end
      end

      n_out = (n_kept > OutLimit) ? OutLimit : n_kept;
      for (int i = 0; i < n_out; i++) begin
        r.sel_start  = start_mem[kept_pos[i]];
        r.sel_end    = end_mem[kept_pos[i]];
        r.sel_index  = SelIdxW'(i);
        r.sel_total  = SelTotW'(n_out);
        r.final_flag = (i + 1 == n_out);
        r.overflow   = dropped;
        kept_q.push_back(r);
      end

      n_sets++;
      if (dropped) n_overflow_sets++;
      n_loaded = 0;
      dropped  = 1'b0;
    endfunction

    task check_result(input res_item_t got);
      res_item_t want;
      if (kept_q.size() == 0) begin
        report($sformatf("unexpected result start %0d end %0d", got.sel_start, got.sel_end));
        return;
      end
      want = kept_q.pop_front();
      n_checked++;
      if (got.sel_start !== want.sel_start)
        report($sformatf("sel_start got %0d want %0d", got.sel_start, want.sel_start));
      if (got.sel_end !== want.sel_end)
        report($sformatf("sel_end got %0d want %0d", got.sel_end, want.sel_end));
      if (got.sel_index !== want.sel_index)
        report($sformatf("sel_index got %0d want %0d", got.sel_index, want.sel_index));
      if (got.sel_total !== want.sel_total)
        report($sformatf("sel_total got %0d want %0d", got.sel_total, want.sel_total));
      if (got.final_flag !== want.final_flag)
        report($sformatf("final_flag got %b want %b", got.final_flag, want.final_flag));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
    endtask
  endclass

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_i    = '0;
  logic      busy;
  logic      res_strobe_o;
  res_item_t res_o;
  int        cycle_cnt = 0;
  bit        no_gaps   = 1'b0;

  sched_scoreboard sb = new();

  interval_scheduling_select u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_result(res_o);
  end

  // Entered and left at a rising edge; returns at the edge of the transfer.
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  task automatic maybe_pause();
    if (!no_gaps && $urandom_range(99) < 15) begin
      start <= 1'b0;
      if ($urandom_range(7) == 0) repeat ($urandom_range(4, 40)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_set(input in_item_t set_q [$]);
    foreach (set_q[i]) begin
      maybe_pause();
      send_item(set_q[i]);
    end
  endtask

  function automatic in_item_t make_interval(input int flavor, input bit last);
    in_item_t it;
    int       lo;
    case (flavor)
      0: begin
        it.iv_start = DataW'($urandom());
        it.iv_end   = DataW'($urandom());
      end
      1: begin
        // Short, dense intervals so that ties and overlaps are common.
        lo          = $urandom_range(60) - 30;
        it.iv_start = DataW'(lo);
        it.iv_end   = DataW'(lo + $urandom_range(15));
      end
      default: begin
        it.iv_start = $urandom_range(1) ? DataW'(-32768 + $urandom_range(7))
                                        : DataW'(32767 - $urandom_range(7));
        it.iv_end   = $urandom_range(1) ? DataW'(-32768 + $urandom_range(7))
                                        : DataW'(32767 - $urandom_range(7));
      end
    endcase
    it.is_last = last;
    return it;
  endfunction

  initial begin
    in_item_t set_q [$];
    int       n_set;
    int       flavor;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single interval spanning the whole range.
    set_q = '{'{iv_start: -16'sd32768, iv_end: 16'sd32767, is_last: 1'b1}};
    send_set(set_q);

    // A reversed interval, three equal ends, and a start equal to the last kept end.
    set_q = '{'{iv_start: 16'sd10, iv_end: 16'sd5, is_last: 1'b0},
              '{iv_start: 16'sd0,  iv_end: 16'sd5, is_last: 1'b0},
              '{iv_start: 16'sd5,  iv_end: 16'sd5, is_last: 1'b0},
              '{iv_start: -16'sd3, iv_end: 16'sd2, is_last: 1'b1}};
    send_set(set_q);

    // Full store of disjoint intervals in falling order, closed by a dropped item.
    set_q = {};
    for (int i = 15; i >= 0; i--) begin
      set_q.push_back('{iv_start: DataW'(i * 100 - 800), iv_end: DataW'(i * 100 - 750),
                        is_last: 1'b0});
    end
    set_q.push_back('{iv_start: 16'sd32767, iv_end: -16'sd32768, is_last: 1'b1});
    send_set(set_q);

    while (sb.n_items < 115) begin
      no_gaps = (sb.n_items >= 60 && sb.n_items < 100);
      n_set   = ($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 10);
      flavor  = $urandom_range(9);
      flavor  = (flavor < 5) ? 1 : (flavor < 8) ? 0 : 2;
      set_q   = {};
      for (int i = 0; i < n_set; i++) begin
        set_q.push_back(make_interval(flavor, i == n_set - 1));
      end
      send_set(set_q);
    end
    start <= 1'b0;

    while (sb.kept_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.kept_q.size() != 0) sb.report("predicted results never arrived");

    $display("Ran %0d items in %0d sets, %0d of them with dropped items.",
             sb.n_items, sb.n_sets, sb.n_overflow_sets);
    $display("Checked %0d selected intervals, %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
